[hdl/swk_pkg.sv]
package swk_pkg;

    localparam int VelW    = 16;
    localparam int CfgW    = 16;
    localparam int IdxW    = 3;
    localparam int WheelW  = 3;
    localparam int ZW      = 26;
    localparam int CordW   = 45;
    localparam int Steps   = 21;

    localparam logic [IdxW-1:0] REG_FRONT   = 3'd0;
    localparam logic [IdxW-1:0] REG_MIDDLE  = 3'd1;
    localparam logic [IdxW-1:0] REG_REAR    = 3'd2;
    localparam logic [IdxW-1:0] REG_TRACK   = 3'd3;
    localparam logic [IdxW-1:0] REG_TIMEOUT = 3'd4;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [WheelW-1:0] LAST_WHEEL = 3'd5;

    localparam logic signed [ZW-1:0] Q20_PI      = 26'sd3294199;
    localparam logic signed [ZW-1:0] Q20_HALF_PI = 26'sd1647099;
    localparam logic signed [17:0]   ANGLE_MIN   = -18'sd19303;
    localparam logic signed [17:0]   ANGLE_MAX   = 18'sd6434;

    // body velocity reference handed to the back end
    typedef struct packed {
        logic signed [VelW-1:0] vx;
        logic signed [VelW-1:0] vy;
        logic signed [VelW-1:0] wz;
    } job_t;

    // wheel geometry registers
    typedef struct packed {
        logic [CfgW-1:0] front;
        logic [CfgW-1:0] middle;
        logic [CfgW-1:0] rear;
        logic [CfgW-1:0] track;
    } geom_t;

    // arctangent table, q20 radians
    function automatic logic [19:0] atan_entry(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/swk_front.sv]
module swk_front import swk_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IdxW-1:0]       cfg_index,
    input  logic [CfgW-1:0]       cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output job_t                  q_job,
    output geom_t                 geom
);

    logic [CfgW-1:0] front_reg, middle_reg, rear_reg, track_reg, timeout_reg;
    job_t            pend_reg, act_reg, act_next;
    logic            pvalid_reg, pvalid_next;
    logic [15:0]     age_reg;
    logic            acc;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && s_tready;
    assign geom      = '{front: front_reg, middle: middle_reg, rear: rear_reg,
                         track: track_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= 16'd512;
            middle_reg  <= 16'd0;
            rear_reg    <= 16'd512;
            track_reg   <= 16'd512;
            timeout_reg <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRONT:   front_reg   <= cfg_data;
                REG_MIDDLE:  middle_reg  <= cfg_data;
                REG_REAR:    rear_reg    <= cfg_data;
                REG_TRACK:   track_reg   <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // refresh of the active reference on a tick
    always_comb begin
        act_next    = act_reg;
        pvalid_next = pvalid_reg;
        if (pvalid_reg) begin
            if (timeout_reg == 16'd0 || age_reg <= timeout_reg) begin
                act_next = pend_reg;
            end else begin
                act_next    = '0;
                pvalid_next = 1'b0;
            end
        end
    end

    assign q_push = acc && (s_tuser == KIND_TICK);
    assign q_job  = act_next;

    // reference state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            act_reg    <= '0;
            pvalid_reg <= 1'b0;
            age_reg    <= 16'd0;
        end else if (acc) begin
            if (s_tuser == KIND_CMD) begin
                pend_reg   <= '{vx: s_tdata[15:0], vy: s_tdata[31:16], wz: s_tdata[47:32]};
                pvalid_reg <= 1'b1;
                age_reg    <= 16'd0;
            end else begin
                act_reg    <= act_next;
                pvalid_reg <= pvalid_next;
                if (age_reg != 16'hFFFF) begin
                    age_reg <= age_reg + 16'd1;
                end
            end
        end
    end

endmodule

[hdl/swk_queue.sv]
module swk_queue import swk_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_job
);

    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_job = mem_reg[rd_reg];

    // two-entry job queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_reg <= !wr_reg;
            end
            if (pop && !empty) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

[hdl/swk_back.sv]
module swk_back import swk_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_empty,
    input  job_t         q_job,
    output logic         q_pop,
    input  geom_t        geom,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic         m_tlast
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_MULX = 4'd1;
    localparam logic [3:0] B_MULY = 4'd2;
    localparam logic [3:0] B_FINY = 4'd3;
    localparam logic [3:0] B_SQ1  = 4'd4;
    localparam logic [3:0] B_SQ2  = 4'd5;
    localparam logic [3:0] B_SQRT = 4'd6;
    localparam logic [3:0] B_ANG0 = 4'd7;
    localparam logic [3:0] B_NORM = 4'd8;
    localparam logic [3:0] B_CORD = 4'd9;
    localparam logic [3:0] B_ANGF = 4'd10;
    localparam logic [3:0] B_OUT  = 4'd11;

    logic [3:0]              state_reg;
    job_t                    job_reg;
    logic [WheelW-1:0]       wheel_reg;
    logic signed [34:0]      prod_reg;
    logic signed [36:0]      x_reg, y_reg;
    logic [53:0]             sq_reg;
    logic [55:0]             n_reg, r_reg;
    logic [4:0]              cnt_reg;
    logic                    big_reg;
    logic [15:0]             speed_reg;
    logic signed [CordW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [15:0]             angle_reg;
    logic                    mv_reg;
    logic [39:0]             md_reg;
    logic                    ml_reg;

    logic                    neg_s, zero_ref, load_out;
    logic signed [18:0]      px2;
    logic signed [17:0]      py2;
    logic signed [34:0]      mul_a, mul_b;
    logic signed [36:0]      x_sum, y_sum;
    logic [36:0]             ax, ay;
    logic [55:0]             bitv, trial;
    logic [55:0]             rnd;
    logic [CordW-1:0]        mcx, mcy, mmax;
    logic signed [CordW-1:0] shx, shy;
    logic signed [ZW-1:0]    tab_z, a_sum;
    logic signed [17:0]      a_q;

    assign neg_s    = job_reg.wz[VelW-1];
    assign zero_ref = (job_reg.vx == '0) && (job_reg.vy == '0) && (job_reg.wz == '0);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_OUT) && (!mv_reg || m_tready);

    // wheel offsets, doubled
    always_comb begin
        case (wheel_reg[2:1])
            2'd0:    px2 = 19'(($signed({1'b0, geom.rear}) - $signed({1'b0, geom.middle})) * 2);
            2'd1:    px2 = -$signed({2'b0, geom.middle, 1'b0});
            default: px2 = -$signed({1'b0, 17'({1'b0, geom.middle} + {1'b0, geom.front}), 1'b0});
        endcase
        py2 = wheel_reg[0] ? $signed({2'b0, geom.track}) : -$signed({2'b0, geom.track});
    end

    // shared multiplier operands, and helpers for the square root, vectoring and angle
    always_comb begin
        mul_a = 35'(job_reg.wz);
        mul_b = (state_reg == B_MULX) ? 35'(px2) : 35'(py2);
        x_sum = 37'(prod_reg) - (37'(job_reg.vy) <<< 11);
        y_sum = 37'(prod_reg) + (37'(job_reg.vx) <<< 11);
        ax    = x_reg[36] ? 37'(-x_reg) : 37'(x_reg);
        ay    = y_reg[36] ? 37'(-y_reg) : 37'(y_reg);
        bitv  = 56'(1) << {cnt_reg, 1'b0};
        trial = r_reg + bitv;
        rnd   = (r_reg + 56'd1024) >> 11;
        mcx   = cx_reg[CordW-1] ? CordW'(-cx_reg) : CordW'(cx_reg);
        mcy   = cy_reg[CordW-1] ? CordW'(-cy_reg) : CordW'(cy_reg);
        mmax  = (mcx > mcy) ? mcx : mcy;
        shx   = cx_reg >>> cnt_reg;
        shy   = cy_reg >>> cnt_reg;
        tab_z = ZW'($signed({1'b0, atan_entry(cnt_reg)}));
        a_sum = z_reg - Q20_HALF_PI + ZW'(128);
        a_q   = 18'(a_sum >>> 8);
    end

    // wheel sequencer: products, square root, vectoring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_job;
                        wheel_reg <= '0;
                        state_reg <= B_MULX;
                    end
                end
                B_MULX: begin
                    prod_reg  <= 35'(mul_a * mul_b);
                    state_reg <= B_MULY;
                end
                B_MULY: begin
                    x_reg     <= neg_s ? -x_sum : x_sum;
                    prod_reg  <= 35'(mul_a * mul_b);
                    state_reg <= B_FINY;
                end
                B_FINY: begin
                    y_reg     <= neg_s ? -y_sum : y_sum;
                    state_reg <= B_SQ1;
                end
                B_SQ1: begin
                    big_reg   <= (ax[36:27] != '0) || (ay[36:27] != '0);
                    sq_reg    <= 54'(ax[26:0]) * 54'(ax[26:0]);
                    state_reg <= B_SQ2;
                end
                B_SQ2: begin
                    n_reg     <= 56'(sq_reg) + 56'(54'(ay[26:0]) * 54'(ay[26:0]));
                    r_reg     <= '0;
                    cnt_reg   <= 5'd27;
                    state_reg <= B_SQRT;
                end
                B_SQRT: begin
                    if (n_reg >= trial) begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + bitv;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    if (cnt_reg == 5'd0) begin
                        state_reg <= B_ANG0;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                B_ANG0: begin
                    if (zero_ref) begin
                        speed_reg <= 16'd0;
                    end else if (big_reg || rnd[55:16] != '0) begin
                        speed_reg <= 16'hFFFF;
                    end else begin
                        speed_reg <= rnd[15:0];
                    end
                    cnt_reg <= 5'd0;
                    if (y_reg == '0) begin
                        z_reg     <= x_reg[36] ? Q20_PI : '0;
                        state_reg <= B_ANGF;
                    end else if (x_reg == '0) begin
                        z_reg     <= y_reg[36] ? -Q20_HALF_PI : Q20_HALF_PI;
                        state_reg <= B_ANGF;
                    end else begin
                        if (x_reg[36]) begin
                            z_reg  <= y_reg[36] ? -Q20_PI : Q20_PI;
                            cx_reg <= CordW'(-x_reg);
                            cy_reg <= CordW'(-y_reg);
                        end else begin
                            z_reg  <= '0;
                            cx_reg <= CordW'(x_reg);
                            cy_reg <= CordW'(y_reg);
                        end
                        state_reg <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (mmax[CordW-1:32] == '0) begin
                        cx_reg <= cx_reg <<< 8;
                        cy_reg <= cy_reg <<< 8;
                    end else if (mmax[CordW-1:40] == '0) begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end else begin
                        state_reg <= B_CORD;
                    end
                end
                B_CORD: begin
                    if (!cy_reg[CordW-1]) begin
                        cx_reg <= cx_reg + shy;
                        cy_reg <= cy_reg - shx;
                        z_reg  <= z_reg + tab_z;
                    end else begin
                        cx_reg <= cx_reg - shy;
                        cy_reg <= cy_reg + shx;
                        z_reg  <= z_reg - tab_z;
                    end
                    if (cnt_reg == 5'(Steps - 1)) begin
                        state_reg <= B_ANGF;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                B_ANGF: begin
                    if (zero_ref) begin
                        angle_reg <= 16'd0;
                    end else if (a_q < ANGLE_MIN) begin
                        angle_reg <= 16'(ANGLE_MIN);
                    end else if (a_q > ANGLE_MAX) begin
                        angle_reg <= 16'(ANGLE_MAX);
                    end else begin
                        angle_reg <= 16'(a_q);
                    end
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (load_out) begin
                        if (wheel_reg == LAST_WHEEL) begin
                            state_reg <= B_IDLE;
                        end else begin
                            wheel_reg <= wheel_reg + 3'd1;
                            state_reg <= B_MULX;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (load_out) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            md_reg <= {5'b0, angle_reg, speed_reg, wheel_reg};
            ml_reg <= wheel_reg == LAST_WHEEL;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

[hdl/six_wheel_steer_kinematics_top.sv]
// a tick is taken from the job queue only when the back end is idle; its six wheels
// are then worked one after another, each through a 28-step square root, up to 11
// normalising steps and 21 vectoring steps, and a stalled result holds the next wheel
// command items never enter the job queue but are held off while it is full;
// two ticks may wait in the job queue
// reset: synchronous active-low aresetn restores register defaults and clears references
module six_wheel_steer_kinematics_top import swk_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [47:0]     s_tdata,   // vel_x, vel_y, yaw_rate
    input  logic            s_tuser,   // kind
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,   // wheel, speed, steer_angle, zero pad
    output logic            m_tlast,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [IdxW-1:0] cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    logic  q_full, q_push, q_pop, q_empty;
    job_t  push_job, pop_job;
    geom_t geom;

    swk_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_full, .q_push, .q_job(push_job), .geom
    );

    swk_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_job, .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_job
    );

    swk_back u_back (
        .aclk, .aresetn, .q_empty, .q_job(pop_job), .q_pop, .geom,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

endmodule

[hdl/swk_checker.sv]
module swk_checker import swk_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // tlast marks exactly the last wheel
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == LAST_WHEEL)))
        else $error("tlast does not match wheel");

    // wheel index in range
    a_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= LAST_WHEEL)
        else $error("wheel index out of range");

    // nothing offered after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind six_wheel_steer_kinematics_top swk_checker u_swk_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

[sim/testbench.sv]
module testbench;
    import swk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one wheel result as seen on the result port
    typedef struct {
        logic [2:0]   wheel;
        logic [15:0]  speed;
        logic [15:0]  angle;
        logic         last;
    } wheel_res_t;

    // steering predictor and store of expected wheel results
    class steer_scoreboard;
        longint unsigned front_off, middle_off, rear_off, track, timeout_lim;
        longint pend_vx, pend_vy, pend_wz, act_vx, act_vy, act_wz;
        bit pend_valid;
        longint unsigned pend_age;
        wheel_res_t wheels_due[$];
        int errors;
        int ticks, cmds, wheels_seen;

        function void reset_state();
            front_off = 512; middle_off = 0; rear_off = 512; track = 512;
            timeout_lim = 0;
            pend_vx = 0; pend_vy = 0; pend_wz = 0; pend_valid = 0; pend_age = 0;
            act_vx = 0; act_vy = 0; act_wz = 0;
        endfunction

        function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
            case (idx)
                REG_FRONT:   front_off = val;
                REG_MIDDLE:  middle_off = val;
                REG_REAR:    rear_off = val;
                REG_TRACK:   track = val;
                REG_TIMEOUT: timeout_lim = val;
                default: ;
            endcase
        endfunction

        // arithmetic shift with floor rounding
        function longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned drive_speed(longint x, longint y);
            longint unsigned ax, ay, r;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            if (ax >= (64'd1 << 27) || ay >= (64'd1 << 27)) return 65535;
            r = (int_sqrt(ax * ax + ay * ay) + 1024) >> 11;
            return r > 65535 ? 65535 : r;
        endfunction

        // cordic vectoring, q20 radians
        function longint vector_angle(longint y, longint x);
            longint z, m, nx, ny, ax, ay;
            z = 0;
            if (y == 0) return x >= 0 ? 0 : Q20_PI;
            if (x == 0) return y > 0 ? Q20_HALF_PI : -Q20_HALF_PI;
            if (x < 0) begin
                z = y > 0 ? Q20_PI : -Q20_PI;
                x = -x;
                y = -y;
            end
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            m = ax > ay ? ax : ay;
            while (m < (64'sd1 << 40)) begin
                x *= 2; y *= 2; m *= 2;
            end
            for (int i = 0; i < Steps; i++) begin
                if (y >= 0) begin
                    nx = x + shr_floor(y, i);
                    ny = y - shr_floor(x, i);
                    z += atan_entry(i[4:0]);
                end else begin
                    nx = x - shr_floor(y, i);
                    ny = y + shr_floor(x, i);
                    z -= atan_entry(i[4:0]);
                end
                x = nx;
                y = ny;
            end
            return z;
        endfunction

        function longint steer_of(longint x, longint y);
            longint a;
            a = shr_floor(vector_angle(y, x) - Q20_HALF_PI + 128, 8);
            if (a < ANGLE_MIN) a = ANGLE_MIN;
            if (a > ANGLE_MAX) a = ANGLE_MAX;
            return a;
        endfunction

        // note an accepted input item
        function void note_input(logic kind, logic [47:0] data);
            longint px2[3], s, tw, py2, x, y;
            wheel_res_t r;
            if (kind == KIND_CMD) begin
                pend_vx = $signed(data[15:0]);
                pend_vy = $signed(data[31:16]);
                pend_wz = $signed(data[47:32]);
                pend_valid = 1;
                pend_age = 0;
                cmds++;
                return;
            end
            ticks++;
            if (pend_valid) begin
                if (timeout_lim == 0 || pend_age <= timeout_lim) begin
                    act_vx = pend_vx; act_vy = pend_vy; act_wz = pend_wz;
                end else begin
                    act_vx = 0; act_vy = 0; act_wz = 0;
                    pend_valid = 0;
                end
            end
            if (pend_age < 65535) pend_age++;
            s = act_wz < 0 ? -1 : 1;
            tw = track;
            px2[0] = 2 * (longint'(rear_off) - longint'(middle_off));
            px2[1] = -2 * longint'(middle_off);
            px2[2] = -2 * (longint'(middle_off) + longint'(front_off));
            for (int k = 0; k < 6; k++) begin
                py2 = k[0] ? tw : -tw;
                x = s * (act_wz * px2[k >> 1] - act_vy * 2048);
                y = s * (act_wz * py2 + act_vx * 2048);
                r.wheel = k[2:0];
                r.speed = 0;
                r.angle = 0;
                if (act_vx != 0 || act_vy != 0 || act_wz != 0) begin
                    r.speed = 16'(drive_speed(x, y));
                    r.angle = 16'(steer_of(x, y));
                end
                r.last = (k == 5);
                wheels_due = {wheels_due, r};
            end
        endfunction

        // check one accepted wheel result
        function void check_result(logic [39:0] data, logic last);
            wheel_res_t e;
            wheels_seen++;
            if (wheels_due.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tlast=%b", $realtime, data, last);
                errors++;
                return;
            end
            e = wheels_due.pop_front();
            if (data[2:0] !== e.wheel) begin
                $display("%0t: wheel expected %0d actual %0d", $realtime, e.wheel, data[2:0]);
                errors++;
            end
            if (data[18:3] !== e.speed) begin
                $display("%0t: speed wheel %0d expected %0d actual %0d", $realtime,
                         e.wheel, e.speed, data[18:3]);
                errors++;
            end
            if (data[34:19] !== e.angle) begin
                $display("%0t: steer wheel %0d expected %0d actual %0d", $realtime,
                         e.wheel, $signed(e.angle), $signed(data[34:19]));
                errors++;
            end
            if (data[39:35] !== 5'd0) begin
                $display("%0t: pad expected 0 actual %h", $realtime, data[39:35]);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: tlast wheel %0d expected %b actual %b", $realtime,
                         e.wheel, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic            aclk = 0;
    logic            aresetn = 0;
    logic            s_tvalid = 0;
    logic            s_tready;
    logic [47:0]     s_tdata = '0;
    logic            s_tuser = 0;
    logic            m_tvalid;
    logic            m_tready = 0;
    logic [39:0]     m_tdata;
    logic            m_tlast;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [IdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0] cfg_data = '0;

    steer_scoreboard sb;
    int idle_cycles = 0;
    bit stall_on = 1;
    bit timed_out = 0;
    localparam int IDLE_LIMIT = 20000;

    six_wheel_steer_kinematics_top uut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // result side: random stalls, check on each transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(negedge aclk) begin
        if (!aresetn || !stall_on) m_tready <= 1;
        else if ($urandom_range(0, 99) < 10) m_tready <= 0;
        else if ($urandom_range(0, 99) < 2) m_tready <= 0;
        else m_tready <= ($urandom_range(0, 99) < 75);
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("%0t: watchdog expired", $realtime);
            $display("Some tests failed");
            $finish;
        end
    end

    // tvalid stays up into the next item when there is no gap
    task automatic send_item(logic kind, logic [47:0] data);
        int g;
        g = pick_gap();
        @(negedge aclk);
        if (g != 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tuser <= kind;
        s_tdata <= data;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, data);
    endtask

    task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz);
        send_item(KIND_CMD, {wz, vy, vx});
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 48'($urandom()));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.wheels_due.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic write_geom(logic [15:0] f, logic [15:0] m, logic [15:0] r, logic [15:0] t,
                              logic [15:0] tmo);
        drain();
        write_reg(REG_FRONT, f);
        write_reg(REG_MIDDLE, m);
        write_reg(REG_REAR, r);
        write_reg(REG_TRACK, t);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: zero reference, extremes, straight, pure rotation
        send_tick();
        send_cmd(16'h0000, 16'h0000, 16'h0000);
        send_tick();
        send_cmd(16'h7fff, 16'h0000, 16'h0000);
        send_tick();
        send_cmd(16'h8000, 16'h8000, 16'h8000);
        send_tick();
        send_cmd(16'h0000, 16'h7fff, 16'h0000);
        send_tick();
        send_cmd(16'h0000, 16'h8000, 16'h0000);
        send_tick();
        send_cmd(16'h0000, 16'h0000, 16'h0001);
        send_tick();
        send_cmd(16'hffff, 16'h7fff, 16'h7fff);
        send_tick();
        send_cmd(16'h0000, 16'h0000, 16'hffff);
        send_tick();

        // wheel at the rotation centre: middle wheels, zero track
        write_geom(16'd512, 16'd0, 16'd512, 16'd0, 16'd2);
        send_cmd(16'h0000, 16'h0000, 16'h0040);
        send_tick();
        // timeout: age within limit, then stale reference zeroes
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        // no reference left: active kept
        send_tick();

        write_geom(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_cmd(16'h7fff, 16'h8000, 16'h7fff);
        send_tick();
        send_cmd(16'h8000, 16'h7fff, 16'h8000);
        send_tick();

        // random phases with different geometry
        for (int ph = 0; ph < 5; ph++) begin
            stall_on = (ph != 2);
            if (ph == 0) write_geom(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            else write_geom(rand_len(), rand_len(), rand_len(), rand_len(),
                            16'($urandom_range(0, 6)));
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(0, 99) < 40)
                    send_cmd(rand_vel(), rand_vel(), rand_vel());
                else
                    send_tick();
                if (i == 20) drain();
            end
        end
        drain();
        stall_on = 0;
        write_reg(3'd7, 16'h1234);
        write_geom(16'd512, 16'd0, 16'd512, 16'd512, 16'd0);
        send_tick();
        drain();

        $display("covered %0d commands and %0d ticks, %0d wheel results checked",
                 sb.cmds, sb.ticks, sb.wheels_seen);
        $display("geometry extremes, timeout expiry and zero reference included");
        if (sb.errors == 0 && sb.wheels_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
